### hw/rtl/mcrb_pkg.sv
// Shared types, constants and ring-pointer helpers for the multi-channel rx ring buffer.
// Used by mcrb_front, mcrb_cmd_fifo, mcrb_back and multi_channel_rx_ring_buffer.
`timescale 1ns / 1ps

package mcrb_pkg;

  localparam int RING_DEPTH   = 8192;
  localparam int NUM_CHANNELS = 4;
  localparam int MAX_READ     = 64;

  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = NUM_CHANNELS * RING_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int NCNT_W    = $clog2(MAX_READ + 1);

  localparam int OP_W    = 3;
  localparam int CH_W    = 2;
  localparam int LIM_W   = 7;
  localparam int STAT_W  = 3;
  localparam int AVAIL_W = 13;
  localparam int CNT_W   = 32;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 160;
  localparam int OUT_PAD = OUT_W - (8 + STAT_W + 1 + AVAIL_W + 4 * CNT_W);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd2;
  localparam logic [OP_W-1:0] OP_INIT  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_DROP   = 3'd1;
  localparam logic [STAT_W-1:0] ST_STALE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOINIT = 3'd4;

  typedef enum logic [2:0] {
    K_WRITE,
    K_READ,
    K_FLUSH,
    K_INIT,
    K_QUERY,
    K_BADCH
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CH_W-1:0]   channel;
    logic [7:0]        data_byte;
    logic              burst_end;
    logic [LIM_W-1:0]  limit;
  } cmd_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                last;
    logic [STAT_W-1:0]   status;
    logic                wake_reader;
    logic [AVAIL_W-1:0]  available;
    logic [CNT_W-1:0]    overflow_total;
    logic [CNT_W-1:0]    rx_total;
    logic [CNT_W-1:0]    burst_writes;
    logic [CNT_W-1:0]    reads_served;
  } res_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD_ISSUE,
    B_RD_DATA
  } bstate_t;

  typedef logic [PTR_W-1:0] ptr_t;

  function automatic ptr_t bump(ptr_t p);
    return (32'(p) == RING_DEPTH - 1) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t held(ptr_t w, ptr_t r);
    logic [PTR_W:0] d;
    if (w >= r) begin
      d = {1'b0, w} - {1'b0, r};
    end else begin
      d = (PTR_W + 1)'(RING_DEPTH) - {1'b0, r} + {1'b0, w};
    end
    return d[PTR_W-1:0];
  endfunction

  function automatic logic [AVAIL_W-1:0] to_avail(ptr_t h);
    logic [31:0] t;
    t = 32'(h);
    return t[AVAIL_W-1:0];
  endfunction

  function automatic logic [MEM_AW-1:0] mem_addr(logic [CH_W-1:0] ch, ptr_t p);
    return MEM_AW'(MEM_AW'(ch) * MEM_AW'(RING_DEPTH) + MEM_AW'(p));
  endfunction

endpackage

### hw/rtl/mcrb_front.sv
// Front end: accepts input beats, decodes opcode, checks channel range, saturates read limit.
// Depends on mcrb_pkg.
`timescale 1ns / 1ps

module mcrb_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // opcode[2:0], channel[4:3], data_byte[12:5], read_limit[19:13], zero pad
  input  logic [mcrb_pkg::IN_W-1:0] s_tdata,
  input  logic                      s_tlast,
  output logic                      cmd_valid,
  input  logic                      cmd_ready,
  output mcrb_pkg::cmd_t            cmd
);

  mcrb_pkg::cmd_t                   cmd_next;
  logic [mcrb_pkg::OP_W-1:0]        opcode;
  logic [mcrb_pkg::CH_W-1:0]        channel;
  logic [mcrb_pkg::LIM_W-1:0]       read_limit;

  assign opcode     = s_tdata[2:0];
  assign channel    = s_tdata[4:3];
  assign read_limit = s_tdata[19:13];
  assign s_tready   = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_next.channel   = channel;
    cmd_next.data_byte = s_tdata[12:5];
    cmd_next.burst_end = s_tlast;
    cmd_next.limit     = (32'(read_limit) > mcrb_pkg::MAX_READ) ?
                         mcrb_pkg::LIM_W'(mcrb_pkg::MAX_READ) : read_limit;
    case (opcode)
      mcrb_pkg::OP_WRITE: cmd_next.kind = mcrb_pkg::K_WRITE;
      mcrb_pkg::OP_READ:  cmd_next.kind = mcrb_pkg::K_READ;
      mcrb_pkg::OP_FLUSH: cmd_next.kind = mcrb_pkg::K_FLUSH;
      mcrb_pkg::OP_INIT:  cmd_next.kind = mcrb_pkg::K_INIT;
      default:            cmd_next.kind = mcrb_pkg::K_QUERY;
    endcase
    if (32'(channel) >= mcrb_pkg::NUM_CHANNELS) begin
      cmd_next.kind = mcrb_pkg::K_BADCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule

### hw/rtl/mcrb_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on mcrb_pkg.
`timescale 1ns / 1ps

module mcrb_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  mcrb_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mcrb_pkg::cmd_t  pop_cmd
);

  mcrb_pkg::cmd_t               entries [mcrb_pkg::QDEPTH];
  logic [mcrb_pkg::QAW-1:0]     wr_idx;
  logic [mcrb_pkg::QAW-1:0]     rd_idx;
  logic [mcrb_pkg::QAW:0]       count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = 32'(count) < mcrb_pkg::QDEPTH;
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_idx];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_idx <= (32'(wr_idx) == mcrb_pkg::QDEPTH - 1) ? '0 : wr_idx + 1'b1;
      end
      if (do_pop) begin
        rd_idx <= (32'(rd_idx) == mcrb_pkg::QDEPTH - 1) ? '0 : rd_idx + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_idx] <= push_cmd;
    end
  end

endmodule

### hw/rtl/mcrb_back.sv
// Back end: per-channel ring state, ring memory, command execution and output register.
// Depends on mcrb_pkg.
`timescale 1ns / 1ps

module mcrb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  mcrb_pkg::cmd_t             cmd,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // out_byte[7:0], status[10:8], wake_reader[11], available[24:12],
  // overflow_total[56:25], rx_total[88:57], burst_writes[120:89],
  // reads_served[152:121], zero pad
  output logic [mcrb_pkg::OUT_W-1:0] m_tdata,
  // byte_valid[0]
  output logic                       m_tuser,
  output logic                       m_tlast
);

  mcrb_pkg::bstate_t             state, state_next;
  mcrb_pkg::ptr_t                wp [mcrb_pkg::NUM_CHANNELS];
  mcrb_pkg::ptr_t                rp [mcrb_pkg::NUM_CHANNELS];
  logic [mcrb_pkg::CNT_W-1:0]    oc [mcrb_pkg::NUM_CHANNELS];
  logic [mcrb_pkg::CNT_W-1:0]    rx [mcrb_pkg::NUM_CHANNELS];
  logic [mcrb_pkg::CNT_W-1:0]    bc [mcrb_pkg::NUM_CHANNELS];
  logic [mcrb_pkg::CNT_W-1:0]    rc [mcrb_pkg::NUM_CHANNELS];
  logic                          rdy [mcrb_pkg::NUM_CHANNELS];

  logic [mcrb_pkg::CH_W-1:0]     cur_ch, cur_ch_next, ch_sel;
  logic [mcrb_pkg::NCNT_W-1:0]   cnt, cnt_next;
  mcrb_pkg::ptr_t                wp_next, rp_next, h;
  logic [mcrb_pkg::CNT_W-1:0]    oc_next, rx_next, bc_next, rc_next;
  logic                          rdy_next;
  logic                          upd;

  logic [7:0]                    ring [mcrb_pkg::MEM_DEPTH];
  logic                          mem_we, mem_re;
  logic [mcrb_pkg::MEM_AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]                    mem_q;

  mcrb_pkg::res_t                res, res_next;
  logic                          res_valid, res_load, out_free;

  assign out_free  = !res_valid || m_tready;
  assign ch_sel    = (state == mcrb_pkg::B_IDLE) ? cmd.channel : cur_ch;
  assign h         = mcrb_pkg::held(wp[ch_sel], rp[ch_sel]);
  assign mem_waddr = mcrb_pkg::mem_addr(ch_sel, wp[ch_sel]);
  assign mem_raddr = mcrb_pkg::mem_addr(cur_ch, rp[cur_ch]);

  always_comb begin
    state_next   = state;
    cur_ch_next  = cur_ch;
    cnt_next     = cnt;
    cmd_ready    = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    res_load     = 1'b0;
    upd          = 1'b0;
    wp_next      = wp[ch_sel];
    rp_next      = rp[ch_sel];
    oc_next      = oc[ch_sel];
    rx_next      = rx[ch_sel];
    bc_next      = bc[ch_sel];
    rc_next      = rc[ch_sel];
    rdy_next     = rdy[ch_sel];
    res_next     = '0;
    res_next.last   = 1'b1;
    res_next.status = mcrb_pkg::ST_OK;

    case (state)
      mcrb_pkg::B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          res_load  = 1'b1;
          upd       = cmd.kind != mcrb_pkg::K_BADCH;
          case (cmd.kind)
            mcrb_pkg::K_WRITE: begin
              if (!rdy[ch_sel]) begin
                res_next.status = mcrb_pkg::ST_NOINIT;
              end else begin
                if (cmd.burst_end) begin
                  bc_next = bc[ch_sel] + 1'b1;
                end
                if (32'(h) >= mcrb_pkg::RING_DEPTH - 1) begin
                  oc_next         = oc[ch_sel] + 1'b1;
                  res_next.status = mcrb_pkg::ST_DROP;
                end else begin
                  mem_we               = 1'b1;
                  wp_next              = mcrb_pkg::bump(wp[ch_sel]);
                  rx_next              = rx[ch_sel] + 1'b1;
                  res_next.wake_reader = h == '0;
                end
              end
            end
            mcrb_pkg::K_READ: begin
              if (!rdy[ch_sel]) begin
                res_next.status = mcrb_pkg::ST_NOINIT;
              end else if (cmd.limit == '0) begin
                res_next.status = mcrb_pkg::ST_OK;
              end else if (oc[ch_sel] != '0) begin
                rp_next         = wp[ch_sel];
                oc_next         = '0;
                res_next.status = mcrb_pkg::ST_STALE;
              end else if (h == '0) begin
                res_next.status = mcrb_pkg::ST_EMPTY;
              end else begin
                rc_next     = rc[ch_sel] + 1'b1;
                res_load    = 1'b0;
                cur_ch_next = ch_sel;
                cnt_next    = (32'(h) < 32'(cmd.limit)) ?
                              mcrb_pkg::NCNT_W'(h) : mcrb_pkg::NCNT_W'(cmd.limit);
                state_next  = mcrb_pkg::B_RD_ISSUE;
              end
            end
            mcrb_pkg::K_FLUSH: begin
              if (!rdy[ch_sel]) begin
                res_next.status = mcrb_pkg::ST_NOINIT;
              end else begin
                rp_next = wp[ch_sel];
              end
            end
            mcrb_pkg::K_INIT: begin
              wp_next  = '0;
              rp_next  = '0;
              oc_next  = '0;
              rx_next  = '0;
              rc_next  = '0;
              rdy_next = 1'b1;
            end
            mcrb_pkg::K_BADCH: begin
              res_next.status = mcrb_pkg::ST_NOINIT;
            end
            default: begin
            end
          endcase
        end
      end
      mcrb_pkg::B_RD_ISSUE: begin
        mem_re     = 1'b1;
        state_next = mcrb_pkg::B_RD_DATA;
      end
      mcrb_pkg::B_RD_DATA: begin
        if (out_free) begin
          res_load            = 1'b1;
          upd                 = 1'b1;
          rp_next             = mcrb_pkg::bump(rp[ch_sel]);
          res_next.out_byte   = mem_q;
          res_next.byte_valid = 1'b1;
          res_next.last       = cnt == mcrb_pkg::NCNT_W'(1);
          cnt_next            = cnt - 1'b1;
          state_next          = (cnt == mcrb_pkg::NCNT_W'(1)) ?
                                mcrb_pkg::B_IDLE : mcrb_pkg::B_RD_ISSUE;
        end
      end
      default: begin
        state_next = mcrb_pkg::B_IDLE;
      end
    endcase

    // reported state is the state after this result
    res_next.available      = rdy_next ? mcrb_pkg::to_avail(mcrb_pkg::held(wp_next, rp_next))
                                       : '0;
    res_next.overflow_total = oc_next;
    res_next.rx_total       = rx_next;
    res_next.burst_writes   = bc_next;
    res_next.reads_served   = rc_next;
    if (state == mcrb_pkg::B_IDLE && cmd.kind == mcrb_pkg::K_BADCH) begin
      res_next.available      = '0;
      res_next.overflow_total = '0;
      res_next.rx_total       = '0;
      res_next.burst_writes   = '0;
      res_next.reads_served   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcrb_pkg::B_IDLE;
      res_valid <= 1'b0;
      cur_ch    <= '0;
      cnt       <= '0;
      for (int i = 0; i < mcrb_pkg::NUM_CHANNELS; i++) begin
        wp[i]  <= '0;
        rp[i]  <= '0;
        oc[i]  <= '0;
        rx[i]  <= '0;
        bc[i]  <= '0;
        rc[i]  <= '0;
        rdy[i] <= 1'b0;
      end
    end else begin
      state  <= state_next;
      cur_ch <= cur_ch_next;
      cnt    <= cnt_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
      if (upd) begin
        wp[ch_sel]  <= wp_next;
        rp[ch_sel]  <= rp_next;
        oc[ch_sel]  <= oc_next;
        rx[ch_sel]  <= rx_next;
        bc[ch_sel]  <= bc_next;
        rc[ch_sel]  <= rc_next;
        rdy[ch_sel] <= rdy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= cmd.data_byte;
    end
    if (mem_re) begin
      mem_q <= ring[mem_raddr];
    end
  end

  assign m_tvalid = res_valid;
  assign m_tuser  = res.byte_valid;
  assign m_tlast  = res.last;
  assign m_tdata  = {{mcrb_pkg::OUT_PAD{1'b0}}, res.reads_served, res.burst_writes,
                     res.rx_total, res.overflow_total, res.available,
                     res.wake_reader, res.status, res.out_byte};

endmodule

### hw/rtl/multi_channel_rx_ring_buffer.sv
// Top level of the multi-channel rx ring buffer: front end, command queue, back end.
// Depends on mcrb_pkg, mcrb_front, mcrb_cmd_fifo and mcrb_back.
`timescale 1ns / 1ps

// Four receive channels, each with an 8192-byte ring (one slot kept free, so 8191 bytes
// usable) in one shared single-write, single-read ring memory. Every input beat gives one
// result beat, except a read that returns n bytes, which gives n beats (last on the final
// one). The front end takes one beat per cycle while the two-entry command queue has room.
// In the back end a write, flush, initialize, query or dataless read is done in the idle
// state; a read that returns n bytes steps, per byte, through an address state and a data
// state for the registered ring-memory read, and takes no new command until its last byte.
// The output register holds each result until it is taken; the back end starts its next
// command or byte no earlier than the cycle in which the held result is accepted. No clearing
// pass follows reset; ring contents are meaningful only once written.

module multi_channel_rx_ring_buffer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // opcode[2:0], channel[4:3], data_byte[12:5], read_limit[19:13], zero pad
  input  logic [mcrb_pkg::IN_W-1:0]  s_tdata,
  // burst_end
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // out_byte[7:0], status[10:8], wake_reader[11], available[24:12],
  // overflow_total[56:25], rx_total[88:57], burst_writes[120:89],
  // reads_served[152:121], zero pad
  output logic [mcrb_pkg::OUT_W-1:0] m_tdata,
  // byte_valid[0]
  output logic                       m_tuser,
  // last
  output logic                       m_tlast
);

  logic            f_valid, f_ready;
  mcrb_pkg::cmd_t  f_cmd;
  logic            q_valid, q_ready;
  mcrb_pkg::cmd_t  q_cmd;

  mcrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  mcrb_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  mcrb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[10:8] == mcrb_pkg::ST_OK)
    else $error("read byte beat with non-ok status");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10:8] != mcrb_pkg::ST_OK |-> m_tlast)
    else $error("error status on a beat that is not last");

  a_wake: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> !m_tuser && m_tdata[10:8] == mcrb_pkg::ST_OK &&
                               m_tdata[24:12] == 13'd1)
    else $error("wake without a single stored byte");

endmodule

### test/multi_channel_rx_ring_buffer_tb.sv
// Self-checking testbench for multi_channel_rx_ring_buffer: directed rows and random
// traffic, each result beat checked against an in-bench ring predictor.
// Depends on mcrb_pkg and the multi_channel_rx_ring_buffer RTL.
`timescale 1ns / 1ps

module multi_channel_rx_ring_buffer_tb;
  import mcrb_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;
  localparam int RANDOM_ITEMS = 445;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CH_W-1:0]    ch;
    logic [7:0]         data_byte;
    logic               burst_end;
    logic [LIM_W-1:0]   limit;
    logic               typed;
    logic [STAT_W-1:0]  status;
    logic [AVAIL_W-1:0] available;
  } dir_row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tuser;
  logic              m_tlast;

  // predictor state, one entry per channel
  logic [7:0]  ring_img [NUM_CHANNELS][RING_DEPTH];
  int          wr_idx [NUM_CHANNELS];
  int          rd_idx [NUM_CHANNELS];
  logic [31:0] drop_cnt [NUM_CHANNELS];
  logic [31:0] stored_cnt [NUM_CHANNELS];
  logic [31:0] burst_cnt [NUM_CHANNELS];
  logic [31:0] serve_cnt [NUM_CHANNELS];
  bit          chan_on [NUM_CHANNELS];

  res_t beats_due [$];
  bit   calm = 1'b0;
  int   n_err = 0;
  int   n_items = 0;
  int   n_beats = 0;
  int   n_bytes = 0;
  int   cycles = 0;

  multi_channel_rx_ring_buffer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int fill_level(int c);
    return (wr_idx[c] >= rd_idx[c]) ? wr_idx[c] - rd_idx[c]
                                    : RING_DEPTH - rd_idx[c] + wr_idx[c];
  endfunction

  function automatic int next_idx(int p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic res_t make_beat(int c, logic [7:0] b, logic v, logic l,
                                     logic [STAT_W-1:0] st, logic wk);
    res_t r;
    r.out_byte       = b;
    r.byte_valid     = v;
    r.last           = l;
    r.status         = st;
    r.wake_reader    = wk;
    r.available      = chan_on[c] ? AVAIL_W'(fill_level(c)) : '0;
    r.overflow_total = drop_cnt[c];
    r.rx_total       = stored_cnt[c];
    r.burst_writes   = burst_cnt[c];
    r.reads_served   = serve_cnt[c];
    return r;
  endfunction

  // advance the ring state by one accepted beat and queue the beats it should produce
  task automatic apply_rx_item(logic [OP_W-1:0] op, int c, logic [7:0] d, logic be,
                               logic [LIM_W-1:0] lim);
    int lvl;
    int n;
    int cap;
    logic [7:0] b;
    cap = (int'(lim) > MAX_READ) ? MAX_READ : int'(lim);
    case (op)
      OP_WRITE: begin
        if (!chan_on[c]) begin
          beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_NOINIT, 1'b0));
        end else begin
          lvl = fill_level(c);
          if (be) burst_cnt[c]++;
          if (lvl >= RING_DEPTH - 1) begin
            drop_cnt[c]++;
            beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_DROP, 1'b0));
          end else begin
            ring_img[c][wr_idx[c]] = d;
            wr_idx[c] = next_idx(wr_idx[c]);
            stored_cnt[c]++;
            beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_OK, lvl == 0));
          end
        end
      end
      OP_READ: begin
        if (!chan_on[c]) begin
          beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_NOINIT, 1'b0));
        end else if (cap == 0) begin
          beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_OK, 1'b0));
        end else if (drop_cnt[c] != 0) begin
          rd_idx[c] = wr_idx[c];
          drop_cnt[c] = 0;
          beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_STALE, 1'b0));
        end else if (fill_level(c) == 0) begin
          beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_EMPTY, 1'b0));
        end else begin
          n = (fill_level(c) < cap) ? fill_level(c) : cap;
          serve_cnt[c]++;
          for (int i = 0; i < n; i++) begin
            b = ring_img[c][rd_idx[c]];
            rd_idx[c] = next_idx(rd_idx[c]);
            beats_due.push_back(make_beat(c, b, 1'b1, i == n - 1, ST_OK, 1'b0));
          end
        end
      end
      OP_FLUSH: begin
        if (!chan_on[c]) begin
          beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_NOINIT, 1'b0));
        end else begin
          rd_idx[c] = wr_idx[c];
          beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_OK, 1'b0));
        end
      end
      OP_INIT: begin
        wr_idx[c] = 0;
        rd_idx[c] = 0;
        drop_cnt[c] = 0;
        stored_cnt[c] = 0;
        serve_cnt[c] = 0;
        chan_on[c] = 1'b1;
        beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_OK, 1'b0));
      end
      default: begin
        beats_due.push_back(make_beat(c, 8'h00, 1'b0, 1'b1, ST_OK, 1'b0));
      end
    endcase
  endtask

  task automatic push_item(logic [OP_W-1:0] op, int c, logic [7:0] d, logic be,
                           logic [LIM_W-1:0] lim);
    while (!calm && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({lim, d, CH_W'(c), op});
    s_tlast  <= be;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_rx_item(op, c, d, be, lim);
    n_items++;
  endtask

  task automatic fill_ring(int c, int n);
    for (int i = 0; i < n; i++) begin
      push_item(OP_WRITE, c, 8'($urandom_range(255)), $urandom_range(7) == 0,
                LIM_W'($urandom_range(127)));
    end
  endtask

  task automatic random_item();
    int pick;
    int c;
    logic [OP_W-1:0] op;
    logic [LIM_W-1:0] lim;
    pick = $urandom_range(99);
    c = $urandom_range(NUM_CHANNELS - 1);
    if (pick < 50) op = OP_WRITE;
    else if (pick < 75) op = OP_READ;
    else if (pick < 81) op = OP_FLUSH;
    else if (pick < 83) op = OP_INIT;
    else if (pick < 91) op = OP_QUERY;
    else if (pick < 94) op = OP_RSVD_A;
    else if (pick < 97) op = OP_RSVD_B;
    else op = OP_RSVD_C;
    pick = $urandom_range(99);
    if (pick < 8) lim = '0;
    else if (pick < 65) lim = LIM_W'($urandom_range(8, 1));
    else if (pick < 90) lim = LIM_W'($urandom_range(64, 9));
    else lim = LIM_W'($urandom_range(127, 65));
    push_item(op, c, 8'($urandom_range(255)), 1'($urandom_range(1)), lim);
  endtask

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      n_err++;
      $display("%0t: beat %0d %s mismatch, expected %0h, actual %0h",
               $time, n_beats, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 25);
  end

  always @(posedge clk) begin : beat_check
    res_t want;
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.out_byte       = m_tdata[7:0];
      got.byte_valid     = m_tuser;
      got.last           = m_tlast;
      got.status         = m_tdata[10:8];
      got.wake_reader    = m_tdata[11];
      got.available      = m_tdata[24:12];
      got.overflow_total = m_tdata[56:25];
      got.rx_total       = m_tdata[88:57];
      got.burst_writes   = m_tdata[120:89];
      got.reads_served   = m_tdata[152:121];
      n_beats++;
      if (got.byte_valid) n_bytes++;
      if (beats_due.size() == 0) begin
        n_err++;
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      end else begin
        want = beats_due.pop_front();
        cmp_field("out_byte", want.out_byte, got.out_byte);
        cmp_field("byte_valid", want.byte_valid, got.byte_valid);
        cmp_field("last", want.last, got.last);
        cmp_field("status", want.status, got.status);
        cmp_field("wake_reader", want.wake_reader, got.wake_reader);
        cmp_field("available", want.available, got.available);
        cmp_field("overflow_total", want.overflow_total, got.overflow_total);
        cmp_field("rx_total", want.rx_total, got.rx_total);
        cmp_field("burst_writes", want.burst_writes, got.burst_writes);
        cmp_field("reads_served", want.reads_served, got.reads_served);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d beats outstanding",
               $time, cycles, beats_due.size());
      $display("multi_channel_rx_ring_buffer_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows [25];
    dir_row_t row;
    res_t tail;
    int n;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      wr_idx[c] = 0;
      rd_idx[c] = 0;
      drop_cnt[c] = '0;
      stored_cnt[c] = '0;
      burst_cnt[c] = '0;
      serve_cnt[c] = '0;
      chan_on[c] = 1'b0;
    end
    // op, ch, byte, burst_end, limit, typed, status, available
    dir_rows = '{
      '{OP_WRITE,  2'd0, 8'h00, 1'b1, 7'd0,   1'b1, ST_NOINIT, 13'd0},
      '{OP_READ,   2'd1, 8'h00, 1'b0, 7'd5,   1'b1, ST_NOINIT, 13'd0},
      '{OP_FLUSH,  2'd2, 8'h00, 1'b0, 7'd0,   1'b1, ST_NOINIT, 13'd0},
      '{OP_QUERY,  2'd3, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0},
      '{OP_RSVD_C, 2'd0, 8'hFF, 1'b1, 7'd127, 1'b1, ST_OK,     13'd0},
      '{OP_INIT,   2'd0, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0},
      '{OP_READ,   2'd0, 8'h00, 1'b0, 7'd3,   1'b1, ST_EMPTY,  13'd0},
      '{OP_WRITE,  2'd0, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd1},
      '{OP_WRITE,  2'd0, 8'hFF, 1'b1, 7'd0,   1'b1, ST_OK,     13'd2},
      '{OP_WRITE,  2'd0, 8'hA5, 1'b0, 7'd0,   1'b1, ST_OK,     13'd3},
      '{OP_READ,   2'd0, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd3},
      '{OP_READ,   2'd0, 8'h00, 1'b0, 7'd127, 1'b0, ST_OK,     13'd0},
      '{OP_INIT,   2'd3, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0},
      '{OP_WRITE,  2'd3, 8'h5A, 1'b1, 7'd0,   1'b1, ST_OK,     13'd1},
      '{OP_WRITE,  2'd3, 8'h3C, 1'b0, 7'd0,   1'b1, ST_OK,     13'd2},
      '{OP_FLUSH,  2'd3, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0},
      '{OP_QUERY,  2'd3, 8'h00, 1'b0, 7'd0,   1'b0, ST_OK,     13'd0},
      '{OP_INIT,   2'd1, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0},
      '{OP_INIT,   2'd2, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0},
      '{OP_WRITE,  2'd1, 8'hC3, 1'b1, 7'd0,   1'b1, ST_OK,     13'd1},
      '{OP_READ,   2'd1, 8'h00, 1'b0, 7'd64,  1'b0, ST_OK,     13'd0},
      '{OP_RSVD_A, 2'd2, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0},
      '{OP_RSVD_B, 2'd1, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0},
      '{OP_READ,   2'd2, 8'h00, 1'b0, 7'd1,   1'b1, ST_EMPTY,  13'd0},
      '{OP_INIT,   2'd0, 8'h00, 1'b0, 7'd0,   1'b1, ST_OK,     13'd0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      push_item(row.op, row.ch, row.data_byte, row.burst_end, row.limit);
      if (row.typed) begin
        tail = beats_due.pop_back();
        tail.status = row.status;
        tail.available = row.available;
        beats_due.push_back(tail);
      end
    end

    n = 0;
    while (n < RANDOM_ITEMS) begin
      calm = (n >= 150 && n < 260);
      if ($urandom_range(99) < 20) begin
        // write burst to one channel, burst_end on the final beat
        fill_ring(0, 0);
        begin : burst
          int c;
          int len;
          c = $urandom_range(NUM_CHANNELS - 1);
          len = $urandom_range(12, 2);
          for (int k = 0; k < len; k++) begin
            push_item(OP_WRITE, c, 8'($urandom_range(255)), k == len - 1,
                      LIM_W'($urandom_range(127)));
          end
          n += len;
        end
      end else begin
        random_item();
        n++;
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input beats: directed rows, write bursts and random mixed traffic.",
             n_items);
    $display("Checked %0d result beats, %0d of them read bytes, %0d mismatches.",
             n_beats, n_bytes, n_err);
    if (n_err == 0) begin
      $display("multi_channel_rx_ring_buffer_tb passed");
    end else begin
      $display("multi_channel_rx_ring_buffer_tb failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mcrb_pkg.sv
hw/rtl/mcrb_front.sv
hw/rtl/mcrb_cmd_fifo.sv
hw/rtl/mcrb_back.sv
hw/rtl/multi_channel_rx_ring_buffer.sv
test/multi_channel_rx_ring_buffer_tb.sv
